[design/rgbmed_pkg.sv]
// Package for the RGB 3x3 median filter: pixel, column and result types,
// register codes, reset values and sizing constants.
// Depends on nothing; the column cell and top level refer to it by scope.
package rgbmed_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int MAX_HEIGHT    = 4096;
	localparam int MIN_DIM       = 3;
	localparam int FW_W          = 12;
	localparam int FH_W          = 13;
	localparam int ROW_W         = 12;
	localparam int CX_W          = 11;
	localparam int CY_W          = 12;
	localparam int CMPW          = 14;
	localparam int FIFO_DEPTH    = 8;

	localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
	localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	// index 0: two rows above, 1: one row above, 2: current row
	typedef pixel_t [2:0] column_t;

	typedef struct packed {
		logic            done;
		logic [CY_W-1:0] cy;
		logic [CX_W-1:0] cx;
	} meta_t;

	typedef struct packed {
		logic            done;
		logic [7:0]      mb;
		logic [7:0]      mg;
		logic [7:0]      mr;
		logic [CY_W-1:0] cy;
		logic [CX_W-1:0] cx;
	} result_t;

endpackage

[design/rgbmed_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module rgbmed_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/rgbmed_col_cell.sv]
// One column cell of the 3x3 window: holds three pixels, shifts to its neighbour.
// Depends on rgbmed_pkg.
module rgbmed_col_cell (
	input  logic                 clk,
	input  logic                 en,
	input  rgbmed_pkg::column_t  col_in,
	output rgbmed_pkg::column_t  col_out
);

	rgbmed_pkg::column_t col_q;

	always_ff @(posedge clk) begin
		if (en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

[design/rgbmed_median9.sv]
// Two-stage median-of-nine for one 8-bit channel: sort each column triple,
// then max of lows, median of mids, min of highs, and the median of those three.
// Depends on nothing.
module rgbmed_median9 (
	input  logic            clk,
	input  logic [8:0][7:0] win,
	output logic [7:0]      median
);

	// returns {hi, mid, lo}
	function automatic logic [2:0][7:0] sort3(input logic [7:0] a, b, c);
		logic [7:0] lo1, hi1, lo2, hi2;
		logic [2:0][7:0] r;
		lo1 = (a < b) ? a : b;
		hi1 = (a < b) ? b : a;
		lo2 = (hi1 < c) ? hi1 : c;
		hi2 = (hi1 < c) ? c : hi1;
		r[0] = (lo1 < lo2) ? lo1 : lo2;
		r[1] = (lo1 < lo2) ? lo2 : lo1;
		r[2] = hi2;
		return r;
	endfunction

	logic [2:0][2:0][7:0] sorted_s1;
	logic [7:0]           max_lo_s2;
	logic [7:0]           med_mid_s2;
	logic [7:0]           min_hi_s2;
	logic [2:0][7:0]      lows, mids, highs;
	logic [2:0][7:0]      t_lo, t_mid, t_hi, t_fin;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sorted_s1[k] <= sort3(win[3*k], win[3*k+1], win[3*k+2]);
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lows[k]  = sorted_s1[k][0];
			mids[k]  = sorted_s1[k][1];
			highs[k] = sorted_s1[k][2];
		end
		t_lo  = sort3(lows[0], lows[1], lows[2]);
		t_mid = sort3(mids[0], mids[1], mids[2]);
		t_hi  = sort3(highs[0], highs[1], highs[2]);
	end

	always_ff @(posedge clk) begin
		max_lo_s2  <= t_lo[2];
		med_mid_s2 <= t_mid[1];
		min_hi_s2  <= t_hi[0];
	end

	always_comb begin
		t_fin  = sort3(max_lo_s2, med_mid_s2, min_hi_s2);
		median = t_fin[1];
	end

endmodule

[design/rgbmed_fifo.sv]
// Small result FIFO built from registers; head entry is shown directly.
// Depends on nothing.
module rgbmed_fifo #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic                       out_valid,
	output logic [WIDTH-1:0]           out_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign out_valid = (count_q != '0);
	assign out_data  = mem[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[design/rgb_median3x3_filter.sv]
// Streaming 3x3 median filter for RGB pixels, one pixel a cycle unless input holds off.
// A result passes stage 1, the window cells, the median stages and the result FIFO.
// Throughput: one pixel per cycle sustained; each line RAM takes one read and one write
// a cycle and the column-cell window shifts once per pixel. Input holds off only while
// results in the 8-entry result FIFO and the four pipeline stages together reach 8.
// Reset: position counters to zero, frame size to 640 x 480; line RAMs are not cleared.
module rgb_median3x3_filter #(
	parameter int MAX_WIDTH = rgbmed_pkg::MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
	input  logic        s_axis_tuser,   // start_of_frame
	// master side
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// center_x[10:0], center_y[22:11], median_red[30:23], median_green[38:31],
	// median_blue[46:39], zero[47]
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tlast,   // frame_done
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int CMPW  = rgbmed_pkg::CMPW;
	localparam int ROW_W = rgbmed_pkg::ROW_W;
	localparam int FW_W  = rgbmed_pkg::FW_W;
	localparam int FH_W  = rgbmed_pkg::FH_W;
	localparam int DEPTH = rgbmed_pkg::FIFO_DEPTH;
	localparam int QCW   = $clog2(DEPTH + 1);
	localparam int OCW   = QCW + 1;
	localparam int RES_W = $bits(rgbmed_pkg::result_t);

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [FW_W-1:0]      frame_width_q;
	logic [FH_W-1:0]      frame_height_q;
	logic                 cfg_wr;
	rgbmed_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = rgbmed_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= rgbmed_pkg::FW_RESET;
			frame_height_q <= rgbmed_pkg::FH_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				rgbmed_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
				rgbmed_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			rgbmed_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			rgbmed_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			default:                      prdata = '0;
		endcase
	end

	// Clamp frame size into the range the line RAMs and counters support.
	logic [CMPW-1:0] w_eff, h_eff;

	always_comb begin
		if (CMPW'(frame_width_q) < CMPW'(rgbmed_pkg::MIN_DIM)) begin
			w_eff = CMPW'(rgbmed_pkg::MIN_DIM);
		end else if (CMPW'(frame_width_q) > CMPW'(MAX_WIDTH)) begin
			w_eff = CMPW'(MAX_WIDTH);
		end else begin
			w_eff = CMPW'(frame_width_q);
		end
		if (CMPW'(frame_height_q) < CMPW'(rgbmed_pkg::MIN_DIM)) begin
			h_eff = CMPW'(rgbmed_pkg::MIN_DIM);
		end else if (CMPW'(frame_height_q) > CMPW'(rgbmed_pkg::MAX_HEIGHT)) begin
			h_eff = CMPW'(rgbmed_pkg::MAX_HEIGHT);
		end else begin
			h_eff = CMPW'(frame_height_q);
		end
	end

	// ---------------------------------------------------------------------
	// Input transfer and raster position
	// ---------------------------------------------------------------------
	logic             accept;
	logic [CW-1:0]    col_q, col_cur;
	logic [ROW_W-1:0] row_q, row_cur;
	logic             last_col, last_row, emit_cur;
	rgbmed_pkg::pixel_t pix_in;

	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		// start of frame puts the position back to the top-left corner first
		col_cur  = s_axis_tuser ? '0 : col_q;
		row_cur  = s_axis_tuser ? '0 : row_q;
		last_col = (CMPW'(col_cur) + CMPW'(1)) >= w_eff;
		last_row = (CMPW'(row_cur) + CMPW'(1)) >= h_eff;
		emit_cur = (CMPW'(col_cur) >= CMPW'(2)) && (CMPW'(row_cur) >= CMPW'(2));
		pix_in.red   = s_axis_tdata[7:0];
		pix_in.green = s_axis_tdata[15:8];
		pix_in.blue  = s_axis_tdata[23:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_cur + ROW_W'(1);
			end else begin
				col_q <= col_cur + CW'(1);
				row_q <= row_cur;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: line RAM read returns; write back and load the window
	// ---------------------------------------------------------------------
	logic                valid_s1, emit_s1, fwd_s1;
	logic [CW-1:0]       col_s1;
	rgbmed_pkg::pixel_t  pix_s1;
	rgbmed_pkg::meta_t   meta_s1;
	rgbmed_pkg::pixel_t  fwd_lo_q, fwd_up_q;
	rgbmed_pkg::pixel_t  lo_rd, up_rd, lo_eff, up_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			emit_s1  <= accept && emit_cur;
		end
	end

	always_ff @(posedge clk) begin
		// RAM reads old data when the previous pixel writes the same column:
		// hold its write data and flag the bypass
		fwd_s1   <= valid_s1 && (col_s1 == col_cur);
		fwd_lo_q <= pix_s1;
		fwd_up_q <= lo_eff;
		if (accept) begin
			col_s1       <= col_cur;
			pix_s1       <= pix_in;
			meta_s1.cx   <= rgbmed_pkg::CX_W'(CMPW'(col_cur) - CMPW'(1));
			meta_s1.cy   <= row_cur - ROW_W'(1);
			meta_s1.done <= last_col && last_row;
		end
	end

	assign lo_eff = fwd_s1 ? fwd_lo_q : lo_rd;
	assign up_eff = fwd_s1 ? fwd_up_q : up_rd;

	// Row one above: written with the new pixel
	rgbmed_ram #(
		.WIDTH ($bits(rgbmed_pkg::pixel_t)),
		.DEPTH (MAX_WIDTH)
	) u_line_lower (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (col_s1),
		.wr_data (pix_s1),
		.rd_en   (accept),
		.rd_addr (col_cur),
		.rd_data (lo_rd)
	);

	// Row two above: takes over what the lower line held
	rgbmed_ram #(
		.WIDTH ($bits(rgbmed_pkg::pixel_t)),
		.DEPTH (MAX_WIDTH)
	) u_line_upper (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (col_s1),
		.wr_data (lo_eff),
		.rd_en   (accept),
		.rd_addr (col_cur),
		.rd_data (up_rd)
	);

	// ---------------------------------------------------------------------
	// Window: three column cells, newest on the right, shift once per pixel
	// ---------------------------------------------------------------------
	rgbmed_pkg::column_t new_col;
	rgbmed_pkg::column_t win_col [3];

	always_comb begin
		new_col[0] = up_eff;
		new_col[1] = lo_eff;
		new_col[2] = pix_s1;
	end

	rgbmed_col_cell u_cell2 (.clk(clk), .en(valid_s1), .col_in(new_col),    .col_out(win_col[2]));
	rgbmed_col_cell u_cell1 (.clk(clk), .en(valid_s1), .col_in(win_col[2]), .col_out(win_col[1]));
	rgbmed_col_cell u_cell0 (.clk(clk), .en(valid_s1), .col_in(win_col[1]), .col_out(win_col[0]));

	// ---------------------------------------------------------------------
	// Stages 2 to 4: median network per channel, metadata travels alongside
	// ---------------------------------------------------------------------
	logic [8:0][7:0]   win_r, win_g, win_b;
	logic [7:0]        med_r, med_g, med_b;
	logic              emit_s2, emit_s3, emit_s4;
	rgbmed_pkg::meta_t meta_s2, meta_s3, meta_s4;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				win_r[3*k+i] = win_col[k][i].red;
				win_g[3*k+i] = win_col[k][i].green;
				win_b[3*k+i] = win_col[k][i].blue;
			end
		end
	end

	rgbmed_median9 u_med_r (.clk(clk), .win(win_r), .median(med_r));
	rgbmed_median9 u_med_g (.clk(clk), .win(win_g), .median(med_g));
	rgbmed_median9 u_med_b (.clk(clk), .win(win_b), .median(med_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
			emit_s3 <= 1'b0;
			emit_s4 <= 1'b0;
		end else begin
			emit_s2 <= emit_s1;
			emit_s3 <= emit_s2;
			emit_s4 <= emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		meta_s2 <= meta_s1;
		meta_s3 <= meta_s2;
		meta_s4 <= meta_s3;
	end

	// ---------------------------------------------------------------------
	// Result FIFO and credit: accept only when every item in flight has a slot
	// ---------------------------------------------------------------------
	rgbmed_pkg::result_t res_in, res_out;
	logic                push;
	logic [QCW-1:0]      fifo_count;
	logic [OCW-1:0]      occupancy;

	assign push = emit_s4;

	always_comb begin
		res_in.done = meta_s4.done;
		res_in.mb   = med_b;
		res_in.mg   = med_g;
		res_in.mr   = med_r;
		res_in.cy   = meta_s4.cy;
		res_in.cx   = meta_s4.cx;
	end

	rgbmed_fifo #(
		.WIDTH (RES_W),
		.DEPTH (DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res_in),
		.pop       (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (res_out),
		.count     (fifo_count)
	);

	assign occupancy = OCW'(fifo_count) + OCW'(emit_s1) + OCW'(emit_s2)
		+ OCW'(emit_s3) + OCW'(emit_s4);
	assign s_axis_tready = occupancy < OCW'(DEPTH);

	assign m_axis_tdata = {1'b0, res_out.mb, res_out.mg, res_out.mr, res_out.cy, res_out.cx};
	assign m_axis_tlast = res_out.done;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fifo_count < QCW'(DEPTH)))
		else $error("result pushed into a full FIFO");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occupancy <= OCW'(DEPTH))
		else $error("results in flight exceed FIFO space");

	a_s1_from_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(accept))
		else $error("stage 1 valid without an input transfer");

endmodule

[sim/testbench.sv]
// Testbench for rgb_median3x3_filter: streams RGB frames through the stream ports,
// predicts each 3x3 median result, and checks results and register readback.
// Depends on rgbmed_pkg and the filter top level; needs no files or arguments.
`timescale 1ns / 100ps

module testbench;

	localparam int MAX_W        = rgbmed_pkg::MAX_WIDTH_DEF;
	localparam int MAX_H        = rgbmed_pkg::MAX_HEIGHT;
	localparam int MIN_D        = rgbmed_pkg::MIN_DIM;
	localparam int FW_W         = rgbmed_pkg::FW_W;
	localparam int FH_W         = rgbmed_pkg::FH_W;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 1_500_000;
	localparam int RANDOM_PIXELS = 760;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic               sof;
		rgbmed_pkg::pixel_t px;
	} pixel_item_t;

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_FULL, FILL_CHECKER} fill_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;   // red_in[7:0], green_in[15:8], blue_in[23:16]
	logic        s_axis_tuser  = 1'b0; // start_of_frame
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// center_x[10:0], center_y[22:11], median_red[30:23], median_green[38:31],
	// median_blue[46:39], zero[47]
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;         // frame_done
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [2:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;

	rgb_median3x3_filter DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #6 clk = ~clk;

	// Pixels waiting for the sender, and medians waiting for the receiver
	pixel_item_t         pixel_feed [$];
	rgbmed_pkg::result_t pending_medians [$];

	// Own copy of the filter state: two line stores, the window and the position
	rgbmed_pkg::pixel_t upper_row [MAX_W];
	rgbmed_pkg::pixel_t lower_row [MAX_W];
	rgbmed_pkg::pixel_t win [3][3];
	int unsigned        col_pos = 0;
	int unsigned        row_pos = 0;
	logic [FW_W-1:0]    cfg_width  = rgbmed_pkg::FW_RESET;
	logic [FH_W-1:0]    cfg_height = rgbmed_pkg::FH_RESET;

	// Handshake pacing, set per phase by the sequence below
	int tx_gap_max = 7;
	int rx_gap_max = 7;
	int tx_wait    = 0;
	int rx_wait    = 0;
	int hold_left  = 0;
	bit stall_request = 1'b0;
	bit stall_taken   = 1'b0;

	// Bookkeeping
	int mismatches   = 0;
	int px_queued    = 0;
	int px_accepted  = 0;
	int results_seen = 0;
	int frame_ends   = 0;
	int reg_writes   = 0;
	int cycle_count  = 0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %0d want %0d",
				results_seen, name, got, want));
	endtask

	// Fifth smallest of nine bytes
	function automatic logic [7:0] median9(input logic [71:0] vals);
		logic [7:0] v [9];
		logic [7:0] t;
		int j;
		for (int i = 0; i < 9; i++)
			v[i] = vals[i*8 +: 8];
		for (int i = 1; i < 9; i++) begin
			t = v[i];
			j = i - 1;
			while (j >= 0 && v[j] > t) begin
				v[j+1] = v[j];
				j--;
			end
			v[j+1] = t;
		end
		return v[4];
	endfunction

	// Advance the filter by one pixel; queue the median it produces, if any
	task automatic filter_pixel(input pixel_item_t item);
		int unsigned         w, h, c, r;
		rgbmed_pkg::pixel_t  up, lo;
		logic [71:0]         rv, gv, bv;
		rgbmed_pkg::result_t res;
		bit                  end_col, end_row;
		w = (cfg_width < MIN_D) ? MIN_D : (cfg_width > MAX_W) ? MAX_W : cfg_width;
		h = (cfg_height < MIN_D) ? MIN_D : (cfg_height > MAX_H) ? MAX_H : cfg_height;
		if (item.sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
		r = row_pos;
		up = upper_row[c];
		lo = lower_row[c];
		upper_row[c] = lo;
		lower_row[c] = item.px;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = up;
		win[1][2] = lo;
		win[2][2] = item.px;
		end_col = (c + 1 >= w);
		end_row = (r + 1 >= h);
		if (c >= 2 && r >= 2) begin
			rv = '0;
			gv = '0;
			bv = '0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					rv = {rv[63:0], win[i][j].red};
					gv = {gv[63:0], win[i][j].green};
					bv = {bv[63:0], win[i][j].blue};
				end
			res.cx   = rgbmed_pkg::CX_W'(c - 1);
			res.cy   = rgbmed_pkg::CY_W'(r - 1);
			res.mr   = median9(rv);
			res.mg   = median9(gv);
			res.mb   = median9(bv);
			res.done = end_col && end_row;
			pending_medians.insert(pending_medians.size(), res);
		end
		if (end_col) begin
			col_pos = 0;
			row_pos = end_row ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endtask

	// Sender: offer the next pixel after a drawn gap; predict on each transfer
	always @(posedge clk) begin
		pixel_item_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				filter_pixel(pixel_item_t'({s_axis_tuser, s_axis_tdata}));
				px_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					s_axis_tvalid <= 1'b0;
				end else if (pixel_feed.size() != 0) begin
					nxt = pixel_feed.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= nxt.px;
					s_axis_tuser  <= nxt.sof;
					tx_wait = $urandom_range(0, tx_gap_max);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall for a drawn number of cycles after each transfer, and hold
	// off once for a long stretch so that the result buffer fills and input stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				rx_wait = $urandom_range(0, rx_gap_max);
			if (stall_request && !stall_taken) begin
				hold_left   = HOLD_CYCLES;
				stall_taken = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Monitor: compare every result transfer with the oldest predicted median
	always @(posedge clk) begin
		rgbmed_pkg::result_t want;
		rgbmed_pkg::result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			got = rgbmed_pkg::result_t'({m_axis_tlast, m_axis_tdata[46:0]});
			if (m_axis_tlast)
				frame_ends++;
			if (pending_medians.size() == 0) begin
				report_mismatch($sformatf("result at (%0d,%0d) with nothing pending",
					got.cx, got.cy));
			end else begin
				want = pending_medians.pop_front();
				check_field("center_x",     32'(got.cx),   32'(want.cx));
				check_field("center_y",     32'(got.cy),   32'(want.cy));
				check_field("median_red",   32'(got.mr),   32'(want.mr));
				check_field("median_green", 32'(got.mg),   32'(want.mg));
				check_field("median_blue",  32'(got.mb),   32'(want.mb));
				check_field("frame_done",   32'(got.done), 32'(want.done));
				check_field("pad bit",      32'(m_axis_tdata[47]), 32'(1'b0));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d pixels taken, %0d results pending",
				cycle_count, px_accepted, px_queued, pending_medians.size());
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Queue a run of pixels; only the first may carry the start mark
	task automatic queue_run(input int count, input bit mark_start, input fill_t fill);
		pixel_item_t item;
		for (int k = 0; k < count; k++) begin
			item.sof = mark_start && (k == 0);
			case (fill)
				FILL_ZERO: begin
					item.px = '0;
				end
				FILL_FULL: begin
					item.px = '1;
				end
				FILL_CHECKER: begin
					item.px.red   = (k % 2) ? 8'hFF : 8'h00;
					item.px.green = (k % 2) ? 8'h00 : 8'hFF;
					item.px.blue  = ((k / 3) % 2) ? 8'hFF : 8'h00;
				end
				default: begin
					item.px = rgbmed_pkg::pixel_t'(24'($urandom));
				end
			endcase
			pixel_feed.insert(pixel_feed.size(), item);
			px_queued++;
		end
	endtask

	// Wait until every queued pixel is taken and every median has come out,
	// then let the pipeline drain pixels that give no result
	task automatic wait_idle();
		do @(posedge clk);
		while (px_accepted != px_queued || pending_medians.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic read_check(input rgbmed_pkg::reg_idx_t idx, input logic [31:0] want);
		logic [31:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= 3'(int'(idx) * 4);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== want)
			report_mismatch($sformatf("register %s read %0d want %0d",
				idx.name(), got, want));
	endtask

	// Write a register (upper bits of the bus may carry junk), then read it back
	task automatic write_reg(input rgbmed_pkg::reg_idx_t idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(int'(idx) * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		reg_writes++;
		if (idx == rgbmed_pkg::REG_FRAME_WIDTH) begin
			cfg_width = value[FW_W-1:0];
			read_check(idx, 32'(cfg_width));
		end else begin
			cfg_height = value[FH_W-1:0];
			read_check(idx, 32'(cfg_height));
		end
	endtask

	function automatic logic [31:0] with_junk(input int value, input int bits);
		return (32'($urandom) << bits) | 32'(value);
	endfunction

	initial begin
		int  base;
		int  w_eff, h_eff, n;
		int  variant;
		bit  first_random;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values read back, then part of a first row at the reset frame size
		read_check(rgbmed_pkg::REG_FRAME_WIDTH, 32'(rgbmed_pkg::FW_RESET));
		read_check(rgbmed_pkg::REG_FRAME_HEIGHT, 32'(rgbmed_pkg::FH_RESET));
		queue_run(24, 1'b1, FILL_RANDOM);
		wait_idle();

		// A 10 x 4 frame fills both line stores over the columns that later
		// resized frames reach; hold the receiver off meanwhile with the sender
		// at full speed so that the result buffer fills and input stalls
		write_reg(rgbmed_pkg::REG_FRAME_WIDTH, 32'd10);
		write_reg(rgbmed_pkg::REG_FRAME_HEIGHT, 32'd4);
		tx_gap_max    = 0;
		stall_request = 1'b1;
		queue_run(40, 1'b1, FILL_RANDOM);
		wait_idle();
		tx_gap_max = 7;

		// Width above the maximum acts as the maximum: a long first row, no wrap
		write_reg(rgbmed_pkg::REG_FRAME_WIDTH, 32'd4095);
		write_reg(rgbmed_pkg::REG_FRAME_HEIGHT, 32'd3);
		queue_run(40, 1'b1, FILL_RANDOM);
		wait_idle();

		// Sizes below the minimum act as 3x3: saturated pixels, then a frame
		// with no start mark that relies on the position wrapping by itself
		write_reg(rgbmed_pkg::REG_FRAME_WIDTH, 32'd2);
		write_reg(rgbmed_pkg::REG_FRAME_HEIGHT, 32'd0);
		queue_run(9, 1'b1, FILL_FULL);
		queue_run(9, 1'b0, FILL_CHECKER);
		wait_idle();

		// Shrink the frame under the current position: the next pixel ends
		// its row, and later its frame
		write_reg(rgbmed_pkg::REG_FRAME_WIDTH, 32'd6);
		write_reg(rgbmed_pkg::REG_FRAME_HEIGHT, 32'd5);
		queue_run(6 * 2 + 5, 1'b1, FILL_ZERO);
		wait_idle();
		write_reg(rgbmed_pkg::REG_FRAME_WIDTH, 32'd3);
		queue_run(1, 1'b0, FILL_FULL);
		wait_idle();
		write_reg(rgbmed_pkg::REG_FRAME_HEIGHT, 32'd3);
		queue_run(6, 1'b0, FILL_RANDOM);
		wait_idle();

		// Height above the maximum acts as 4096 rows: a dozen rows, no wrap
		write_reg(rgbmed_pkg::REG_FRAME_WIDTH, 32'd3);
		write_reg(rgbmed_pkg::REG_FRAME_HEIGHT, 32'd8191);
		queue_run(3 * 12, 1'b1, FILL_RANDOM);
		wait_idle();

		// Random phases: mostly small well-formed frames, some truncated,
		// unmarked or noisy, with resizes between phases
		base = px_queued;
		first_random = 1'b1;
		while (px_queued - base < RANDOM_PIXELS) begin
			if (first_random || $urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 15))
					0:       write_reg(rgbmed_pkg::REG_FRAME_WIDTH,
						with_junk($urandom_range(0, 2), FW_W));
					1:       write_reg(rgbmed_pkg::REG_FRAME_WIDTH,
						with_junk($urandom_range(MAX_W + 1, 4095), FW_W));
					2:       write_reg(rgbmed_pkg::REG_FRAME_WIDTH, with_junk(MAX_W, FW_W));
					default: write_reg(rgbmed_pkg::REG_FRAME_WIDTH,
						with_junk($urandom_range(3, 10), FW_W));
				endcase
				case ($urandom_range(0, 15))
					0:       write_reg(rgbmed_pkg::REG_FRAME_HEIGHT,
						with_junk($urandom_range(0, 2), FH_W));
					1:       write_reg(rgbmed_pkg::REG_FRAME_HEIGHT,
						with_junk($urandom_range(MAX_H + 1, 8191), FH_W));
					default: write_reg(rgbmed_pkg::REG_FRAME_HEIGHT,
						with_junk($urandom_range(3, 7), FH_W));
				endcase
			end
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			first_random = 1'b0;
			w_eff = (cfg_width < MIN_D) ? MIN_D : (cfg_width > MAX_W) ? MAX_W : cfg_width;
			h_eff = (cfg_height < MIN_D) ? MIN_D :
				(cfg_height > MAX_H) ? MAX_H : cfg_height;
			n = w_eff * h_eff;
			repeat ($urandom_range(1, 3)) begin
				variant = $urandom_range(0, 9);
				if (n > 200)
					queue_run($urandom_range(30, 80), 1'b1, FILL_RANDOM);
				else if (variant == 0)
					queue_run($urandom_range(1, n - 1), 1'b1, FILL_RANDOM);
				else if (variant == 1)
					queue_run(n, 1'b0, FILL_RANDOM);
				else if (variant == 2)
					queue_run($urandom_range(1, 4), 1'($urandom_range(0, 1)), FILL_RANDOM);
				else
					queue_run(n, 1'b1, FILL_RANDOM);
			end
			wait_idle();
		end

		if (pending_medians.size() != 0)
			report_mismatch($sformatf("%0d medians never came out", pending_medians.size()));
		$display("run covered %0d pixels and %0d median results (%0d frame ends),",
			px_accepted, results_seen, frame_ends);
		$display("with %0d register writes across default, clamped and resized frames",
			reg_writes);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
